// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/pcvd_pkg.sv
// types and constants shared by the pid controller rtl
package pcvd_pkg;

  localparam int VW = 32;          // value width, q16.16
  localparam int FB = 16;          // fraction bits
  localparam int IW = 64;          // integral width
  localparam int XW = VW + 1;      // multiplicand width, holds a negated gain
  localparam int YW = IW;          // multiplier magnitude width
  localparam int AW = XW + YW;     // accumulator width
  localparam int QW = AW - FB;     // dividend width after the fraction shift
  localparam int DW = VW;          // divisor width
  localparam int CW = $clog2(QW + 1);

  localparam logic ACTION_SET_GOAL = 1'b1;

  typedef enum logic [2:0] {
    REG_KP  = 3'd0,
    REG_KI  = 3'd1,
    REG_KD  = 3'd2,
    REG_DIV = 3'd3,
    REG_TOL = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                 action;
    logic signed [VW-1:0] measured;
    logic [VW-1:0]        timestamp_us;
    logic signed [VW-1:0] new_setpoint;
  } req_t;

  typedef struct packed {
    logic signed [VW-1:0] speed;
    logic signed [VW-1:0] position;
    logic signed [VW-1:0] error_now;
    logic                 in_tolerance;
  } rsp_t;

  typedef struct packed {
    logic                 start;
    logic                 load;
    logic signed [XW-1:0] x;
    logic [YW-1:0]        y;
    logic signed [AW-1:0] init;
  } mac_cmd_t;

  typedef struct packed {
    logic          start;
    logic [QW-1:0] dividend;
    logic [DW-1:0] divisor;
    logic [CW-1:0] nbits;
  } div_cmd_t;

endpackage

// File: rtl/core/pcvd_mac.sv
// bit-serial multiply-accumulate, one multiplier bit per cycle
module pcvd_mac import pcvd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  mac_cmd_t             cmd,
  output logic                 busy,
  output logic signed [AW-1:0] acc
);

  logic signed [AW-1:0] addend;
  logic [YW-1:0]        y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (busy && y == '0) begin
      busy <= 1'b0;
    end
    if (cmd.start) begin
      addend <= AW'(cmd.x);
      y      <= cmd.y;
      if (cmd.load) begin
        acc <= cmd.init;
      end
    end else if (busy && y != '0) begin
      if (y[0]) begin
        acc <= acc + addend;
      end
      addend <= addend <<< 1;
      y      <= y >> 1;
    end
  end

endmodule

// File: rtl/core/pcvd_div.sv
// restoring divider, one quotient bit per cycle
module pcvd_div import pcvd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  div_cmd_t      cmd,
  output logic          busy,
  output logic [QW-1:0] quotient
);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;

  assign trial = {rem, quotient[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
    if (cmd.start) begin
      quotient <= cmd.dividend;
      dvs      <= cmd.divisor;
      cnt      <= cmd.nbits;
      rem      <= '0;
    end else if (busy && cnt != '0) begin
      if (trial >= {1'b0, dvs}) begin
        rem      <= DW'(trial - {1'b0, dvs});
        quotient <= {quotient[QW-2:0], 1'b1};
      end else begin
        rem      <= trial[DW-1:0];
        quotient <= {quotient[QW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// File: rtl/core/pid_controller_variable_dt_top.sv
// top level of the pid controller with measured time step
// An update item carries a q16.16 measurement and a microsecond timestamp and
// yields one result (speed, position, error, in-tolerance flag); a set-goal
// item loads the setpoint, clears the integral and yields nothing. One update
// runs through a bit-serial multiply-accumulate unit and a restoring divider,
// each handling one bit per cycle: the integral step (error times dt)
// overlaps the derivative divide, then the three gain products follow one
// after another (each finishing early when the multiplier runs out of set
// bits), then the divide of the weighted sum by output_divisor. Only one item
// is in work at a time; a finished result sits in the output register so the
// next item can be taken while it waits. Configuration is written through
// cfg_we/cfg_index/cfg_data with no handshake.
`include "assert_macros.svh"

module pid_controller_variable_dt_top import pcvd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  req_t          req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rsp_t          rsp,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [VW-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_INT_GO, S_INT_WAIT, S_P_GO, S_P_WAIT, S_I_GO, S_I_WAIT,
    S_D_GO, S_D_WAIT, S_Q_GO, S_Q_WAIT, S_FIN
  } state_t;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  state_t state;

  // configuration registers
  logic signed [VW-1:0] kp, ki, kd;
  logic [15:0]          odiv;
  logic [VW-2:0]        tol;

  // controller state
  logic signed [VW-1:0] goal, prev_err, pos;
  logic [VW-1:0]        prev_time;
  logic signed [IW-1:0] integral;

  // per-item working values
  logic signed [VW-1:0] err, speed;
  logic [VW-1:0]        dt, tstamp;
  logic signed [VW:0]   derr, deriv;

  mac_cmd_t             mac_cmd;
  div_cmd_t             div_cmd;
  logic                 mac_busy, div_busy;
  logic signed [AW-1:0] mac_acc;
  logic [QW-1:0]        div_q;

  logic signed [VW:0]   diff, pos_sum;
  logic signed [VW-1:0] err_next, pos_next;
  logic signed [AW-1:0] acc_sh;
  logic signed [QW-1:0] acc_q;
  logic [QW-1:0]        acc_mag;
  logic [VW-1:0]        err_mag, derr_mag, deriv_mag;
  logic [IW-1:0]        int_mag;
  logic signed [XW-1:0] kp_x, ki_x, kd_x;
  logic signed [IW-1:0] int_clamped;
  logic signed [VW-1:0] speed_next;
  logic signed [VW:0]   tol_s, err_s;
  logic                 tol_flag;

  assign req_ready = (state == S_IDLE);

  // error against the setpoint, saturated
  assign diff     = (VW+1)'(goal) - (VW+1)'(req.measured);
  assign err_next = (diff[VW] != diff[VW-1]) ? (diff[VW] ? VMIN : VMAX) : diff[VW-1:0];

  // magnitudes for the sign-magnitude multiply and divide
  assign err_mag   = err[VW-1] ? VW'(-err) : err;
  assign int_mag   = integral[IW-1] ? IW'(-integral) : integral;
  assign derr_mag  = derr[VW] ? VW'(-derr) : derr[VW-1:0];
  assign deriv_mag = deriv[VW] ? VW'(-deriv) : deriv[VW-1:0];
  assign kp_x      = XW'(kp);
  assign ki_x      = XW'(ki);
  assign kd_x      = XW'(kd);

  // weighted sum with the fraction shifted out, floor rounding
  assign acc_sh  = mac_acc >>> FB;
  assign acc_q   = acc_sh[QW-1:0];
  assign acc_mag = acc_q[QW-1] ? QW'(-acc_q) : acc_q;

  // integral saturates at 64 bits
  always_comb begin
    if (&mac_acc[AW-1:IW-1] || ~|mac_acc[AW-1:IW-1]) begin
      int_clamped = mac_acc[IW-1:0];
    end else begin
      int_clamped = mac_acc[AW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end
  end

  // speed from the quotient magnitude and the sum's sign
  always_comb begin
    if (acc_q[QW-1]) begin
      speed_next = (div_q > QW'({1'b0, VMIN})) ? VMIN : VW'(-div_q[VW-1:0]);
    end else begin
      speed_next = (div_q > QW'(VMAX)) ? VMAX : div_q[VW-1:0];
    end
  end

  assign pos_sum  = (VW+1)'(pos) + (VW+1)'(speed);
  assign pos_next = (pos_sum[VW] != pos_sum[VW-1]) ? (pos_sum[VW] ? VMIN : VMAX)
                                                   : pos_sum[VW-1:0];

  // strictly inside plus/minus tolerance
  assign tol_s    = (VW+1)'({1'b0, tol});
  assign err_s    = (VW+1)'(err);
  assign tol_flag = (err_s > -tol_s) && (err_s < tol_s);

  // commands to the shared serial units
  always_comb begin
    mac_cmd = '0;
    div_cmd = '0;
    unique case (state)
      S_INT_GO: begin
        mac_cmd.start    = 1'b1;
        mac_cmd.load     = 1'b1;
        mac_cmd.init     = AW'(integral);
        mac_cmd.x        = XW'(err);
        mac_cmd.y        = YW'(dt);
        div_cmd.start    = 1'b1;
        div_cmd.dividend = {derr_mag, (QW-VW)'(0)};
        div_cmd.divisor  = dt;
        div_cmd.nbits    = CW'(VW);
      end
      S_P_GO: begin
        mac_cmd.start = 1'b1;
        mac_cmd.load  = 1'b1;
        mac_cmd.x     = err[VW-1] ? -kp_x : kp_x;
        mac_cmd.y     = YW'(err_mag);
      end
      S_I_GO: begin
        mac_cmd.start = 1'b1;
        mac_cmd.x     = integral[IW-1] ? -ki_x : ki_x;
        mac_cmd.y     = YW'(int_mag);
      end
      S_D_GO: begin
        mac_cmd.start = 1'b1;
        mac_cmd.x     = deriv[VW] ? -kd_x : kd_x;
        mac_cmd.y     = YW'(deriv_mag);
      end
      S_Q_GO: begin
        div_cmd.start    = 1'b1;
        div_cmd.dividend = acc_mag;
        div_cmd.divisor  = DW'((odiv == '0) ? 16'd1 : odiv);
        div_cmd.nbits    = CW'(QW);
      end
      default: begin
      end
    endcase
  end

  pcvd_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .busy (mac_busy),
    .acc  (mac_acc)
  );

  pcvd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      kp   <= '0;
      ki   <= '0;
      kd   <= '0;
      odiv <= 16'd1;
      tol  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KP:  kp   <= cfg_data;
        REG_KI:  ki   <= cfg_data;
        REG_KD:  kd   <= cfg_data;
        REG_DIV: odiv <= cfg_data[15:0];
        REG_TOL: tol  <= cfg_data[VW-2:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      goal      <= '0;
      integral  <= '0;
      prev_err  <= '0;
      prev_time <= '0;
      pos       <= '0;
    end else begin
      // the final step refills the output register itself
      if (rsp_valid && rsp_ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.action == ACTION_SET_GOAL) begin
              goal     <= req.new_setpoint;
              integral <= '0;
            end else begin
              err    <= err_next;
              dt     <= req.timestamp_us - prev_time;
              derr   <= (VW+1)'(err_next) - (VW+1)'(prev_err);
              tstamp <= req.timestamp_us;
              state  <= S_INT_GO;
            end
          end
        end
        S_INT_GO: state <= S_INT_WAIT;
        S_INT_WAIT: begin
          if (!mac_busy && !div_busy) begin
            integral <= int_clamped;
            // zero elapsed time holds the derivative at zero
            if (dt == '0) begin
              deriv <= '0;
            end else if (derr[VW]) begin
              deriv <= -(VW+1)'(div_q[VW-1:0]);
            end else begin
              deriv <= (VW+1)'(div_q[VW-1:0]);
            end
            state <= S_P_GO;
          end
        end
        S_P_GO: state <= S_P_WAIT;
        S_P_WAIT: begin
          if (!mac_busy) begin
            state <= S_I_GO;
          end
        end
        S_I_GO: state <= S_I_WAIT;
        S_I_WAIT: begin
          if (!mac_busy) begin
            state <= S_D_GO;
          end
        end
        S_D_GO: state <= S_D_WAIT;
        S_D_WAIT: begin
          if (!mac_busy) begin
            state <= S_Q_GO;
          end
        end
        S_Q_GO: state <= S_Q_WAIT;
        S_Q_WAIT: begin
          if (!div_busy) begin
            speed <= speed_next;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // wait for the output register to free up
          if (!rsp_valid || rsp_ready) begin
            rsp.speed        <= speed;
            rsp.position     <= pos_next;
            rsp.error_now    <= err;
            rsp.in_tolerance <= tol_flag;
            rsp_valid        <= 1'b1;
            pos              <= pos_next;
            prev_time        <= tstamp;
            prev_err         <= err;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an update item always starts the integral step
  `ASSERT_NEXT(a_update_starts, clk, rst,
    req_valid && req_ready && req.action != ACTION_SET_GOAL, state == S_INT_GO)
  // both serial units are idle once the result is ready
  `ASSERT_IMPLIES(a_units_idle, clk, rst, state == S_FIN, !mac_busy && !div_busy)
  // a result appears only out of the final step
  `ASSERT_IMPLIES(a_rsp_source, clk, rst, $rose(rsp_valid), $past(state) == S_FIN)

endmodule
